FILE: src/bmp2rgb_pkg.sv
// Package for the BMP to RGB565 stream decoder.
// Holds the item types, result kinds, parse phases and header constants.
// No dependencies.
`default_nettype none

package bmp2rgb_pkg;

  // Default screen size.
  localparam int ScreenColsDefault = 320;
  localparam int ScreenRowsDefault = 240;

  // Header layout.
  localparam logic [31:0] HdrLen = 32'd54;
  localparam logic [31:0] OffPos = 32'd10;
  localparam logic [31:0] WidPos = 32'd18;
  localparam logic [31:0] HgtPos = 32'd22;
  localparam logic [31:0] FieldLen = 32'd4;

  // Queue between parser and output side.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_HDR_ERR = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_SKIP     = 6'b000010,
    PH_PIXEL    = 6'b000100,
    PH_PAD      = 6'b001000,
    PH_COMPLETE = 6'b010000,
    PH_ENDED    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] color;
    logic        last_in_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] color;
  } result_t;

  // Results of one input byte: the first result, and whether a file-done
  // result follows it.
  typedef struct packed {
    result_t first;
    logic    two;
  } bundle_t;

endpackage

`default_nettype wire

FILE: src/bmp2rgb_front.sv
// Parser of the BMP to RGB565 decoder: header capture, skip, pixel packing.
// Produces one bundle of up to two results per byte. Uses bmp2rgb_pkg.
`default_nettype none

module bmp2rgb_front #(
  parameter int SCREEN_COLS = bmp2rgb_pkg::ScreenColsDefault,
  parameter int SCREEN_ROWS = bmp2rgb_pkg::ScreenRowsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  bmp2rgb_pkg::in_item_t in_item_i,
  output logic                  push_o,
  output bmp2rgb_pkg::bundle_t  bundle_o
);

  localparam int RowW = $clog2(SCREEN_ROWS + 1);

  logic [31:0]         pos_q, pos_d, pos_c;
  logic [31:0]         offset_q, offset_d, offset_c;
  logic [31:0]         width_q, width_d, width_c;
  logic [31:0]         height_q, height_d, height_c;
  logic [31:0]         column_q, column_d, column_c;
  logic [RowW-1:0]     row_q, row_d, row_c;
  logic [1:0]          trip_q, trip_d, trip_c;
  logic [15:0]         held_q, held_d, held_c;
  logic [1:0]          pad_q, pad_d, pad_c;
  bmp2rgb_pkg::phase_e phase_q, phase_d, phase_c;

  logic                 has_res;
  logic                 do_pix;
  logic                 do_end_row;
  logic                 empty_img;
  logic [1:0]           lane;
  logic [RowW-1:0]      row_inc;
  logic                 row_done;
  logic [31:0]          col_inc;
  logic [7:0]           b;
  bmp2rgb_pkg::result_t res;
  bmp2rgb_pkg::result_t eof_res;

  assign b = in_item_i.byte_value;

  // A first byte starts the parse over from the reset values.
  always_comb begin
    if (in_item_i.first_byte) begin
      pos_c    = '0;
      offset_c = '0;
      width_c  = '0;
      height_c = '0;
      column_c = '0;
      row_c    = '0;
      trip_c   = '0;
      held_c   = '0;
      pad_c    = '0;
      phase_c  = bmp2rgb_pkg::PH_HEADER;
    end else begin
      pos_c    = pos_q;
      offset_c = offset_q;
      width_c  = width_q;
      height_c = height_q;
      column_c = column_q;
      row_c    = row_q;
      trip_c   = trip_q;
      held_c   = held_q;
      pad_c    = pad_q;
      phase_c  = phase_q;
    end
  end

  // All header fields start at an offset of 2 modulo 4, so the byte lane
  // within a field follows from the low position bits.
  assign lane      = pos_c[1:0] + 2'd2;
  assign empty_img = (width_c == '0) || (height_c == '0);
  assign row_inc   = row_c + RowW'(1);
  assign row_done  = (32'(row_inc) >= height_c) || (row_inc >= RowW'(SCREEN_ROWS));
  assign col_inc   = column_c + 32'd1;

  always_comb begin
    pos_d      = pos_c;
    offset_d   = offset_c;
    width_d    = width_c;
    height_d   = height_c;
    column_d   = column_c;
    row_d      = row_c;
    trip_d     = trip_c;
    held_d     = held_c;
    pad_d      = pad_c;
    phase_d    = phase_c;
    has_res    = 1'b0;
    res        = '0;
    eof_res    = '0;
    do_pix     = 1'b0;
    do_end_row = 1'b0;
    bundle_o   = '0;
    push_o     = 1'b0;

    if (phase_c != bmp2rgb_pkg::PH_ENDED) begin
      case (phase_c)
        bmp2rgb_pkg::PH_HEADER: begin
          if (pos_c >= bmp2rgb_pkg::OffPos &&
              pos_c < bmp2rgb_pkg::OffPos + bmp2rgb_pkg::FieldLen) begin
            offset_d[8*lane +: 8] = b;
          end else if (pos_c >= bmp2rgb_pkg::WidPos &&
                       pos_c < bmp2rgb_pkg::WidPos + bmp2rgb_pkg::FieldLen) begin
            width_d[8*lane +: 8] = b;
          end else if (pos_c >= bmp2rgb_pkg::HgtPos &&
                       pos_c < bmp2rgb_pkg::HgtPos + bmp2rgb_pkg::FieldLen) begin
            height_d[8*lane +: 8] = b;
          end
          if (pos_c == bmp2rgb_pkg::HdrLen - 32'd1) begin
            has_res  = 1'b1;
            res.kind = bmp2rgb_pkg::KIND_CLEAR;
            if (offset_c > bmp2rgb_pkg::HdrLen) begin
              phase_d = bmp2rgb_pkg::PH_SKIP;
            end else if (empty_img) begin
              phase_d = bmp2rgb_pkg::PH_COMPLETE;
            end else begin
              phase_d = bmp2rgb_pkg::PH_PIXEL;
            end
          end
        end
        bmp2rgb_pkg::PH_SKIP: begin
          if (pos_c >= offset_c) begin
            if (empty_img) begin
              phase_d = bmp2rgb_pkg::PH_COMPLETE;
            end else begin
              phase_d = bmp2rgb_pkg::PH_PIXEL;
              do_pix  = 1'b1;
            end
          end
        end
        bmp2rgb_pkg::PH_PIXEL: begin
          do_pix = 1'b1;
        end
        bmp2rgb_pkg::PH_PAD: begin
          pad_d = (pad_c != 2'd0) ? pad_c - 2'd1 : 2'd0;
          if (pad_d == 2'd0) begin
            do_end_row = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (do_pix) begin
        case (trip_c)
          2'd0: begin
            held_d = {8'h00, b};
            trip_d = 2'd1;
          end
          2'd1: begin
            held_d[15:8] = b;
            trip_d       = 2'd2;
          end
          default: begin
            trip_d = 2'd0;
            if (column_c < 32'(SCREEN_COLS)) begin
              has_res     = 1'b1;
              res.kind    = bmp2rgb_pkg::KIND_PIXEL;
              res.pixel_x = column_c[8:0];
              res.pixel_y = 8'(row_c);
              res.color   = {b[7:3], held_c[15:10], held_c[7:3]};
            end
            if (col_inc == width_c) begin
              column_d = '0;
              // Row padding to four bytes is the low two bits of the width.
              pad_d    = width_c[1:0];
              if (width_c[1:0] == 2'd0) begin
                do_end_row = 1'b1;
              end else begin
                phase_d = bmp2rgb_pkg::PH_PAD;
              end
            end else begin
              column_d = col_inc;
            end
          end
        endcase
      end

      if (do_end_row) begin
        row_d   = row_inc;
        phase_d = row_done ? bmp2rgb_pkg::PH_COMPLETE : bmp2rgb_pkg::PH_PIXEL;
      end

      pos_d = (pos_c == '1) ? pos_c : pos_c + 32'd1;

      if (in_item_i.end_of_file) begin
        eof_res.kind = (phase_d == bmp2rgb_pkg::PH_HEADER) ?
                       bmp2rgb_pkg::KIND_HDR_ERR : bmp2rgb_pkg::KIND_DONE;
        phase_d      = bmp2rgb_pkg::PH_ENDED;
      end

      if (has_res) begin
        bundle_o.first = res;
        bundle_o.two   = in_item_i.end_of_file;
      end else begin
        bundle_o.first = eof_res;
      end
      push_o = accept_i && (has_res || in_item_i.end_of_file);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      column_q <= '0;
      row_q    <= '0;
      trip_q   <= '0;
      held_q   <= '0;
      pad_q    <= '0;
      phase_q  <= bmp2rgb_pkg::PH_HEADER;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      column_q <= column_d;
      row_q    <= row_d;
      trip_q   <= trip_d;
      held_q   <= held_d;
      pad_q    <= pad_d;
      phase_q  <= phase_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmp2rgb_queue.sv
// Short queue of result bundles between the parser and the output side.
// Register based, depth from bmp2rgb_pkg.
`default_nettype none

module bmp2rgb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bmp2rgb_pkg::bundle_t data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output bmp2rgb_pkg::bundle_t head_o
);

  bmp2rgb_pkg::bundle_t                      mem_q [bmp2rgb_pkg::QueueDepth];
  logic [bmp2rgb_pkg::QueuePtrW-1:0]         wr_ptr_q;
  logic [bmp2rgb_pkg::QueuePtrW-1:0]         rd_ptr_q;
  logic [bmp2rgb_pkg::QueueCntW-1:0]         count_q;
  logic                                      do_push;
  logic                                      do_pop;

  assign full_o  = (count_q == bmp2rgb_pkg::QueueCntW'(bmp2rgb_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmp2rgb_back.sv
// Output side of the BMP to RGB565 decoder: unpacks each bundle into one or
// two results and holds them in the output register. Uses bmp2rgb_pkg.
`default_nettype none

module bmp2rgb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  bmp2rgb_pkg::bundle_t   head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bmp2rgb_pkg::out_item_t out_item_o
);

  bmp2rgb_pkg::bundle_t cur_q;
  logic                 valid_q;
  logic                 second_q;
  logic                 last_now;
  logic                 out_accept;

  assign last_now    = second_q || !cur_q.two;
  assign out_accept  = valid_q && !out_stall_i;
  assign pop_o       = !empty_i && (!valid_q || (out_accept && last_now));
  assign out_valid_o = valid_q;

  always_comb begin
    if (second_q) begin
      out_item_o      = '0;
      out_item_o.kind = bmp2rgb_pkg::KIND_DONE;
    end else begin
      out_item_o.kind    = cur_q.first.kind;
      out_item_o.pixel_x = cur_q.first.pixel_x;
      out_item_o.pixel_y = cur_q.first.pixel_y;
      out_item_o.color   = cur_q.first.color;
    end
    out_item_o.last_in_run = last_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (pop_o) begin
      valid_q  <= 1'b1;
      second_q <= 1'b0;
    end else if (out_accept) begin
      if (last_now) begin
        valid_q <= 1'b0;
      end else begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmp24_stream_to_rgb565_pixels.sv
// Top level of the BMP to RGB565 decoder: parser, bundle queue, output side.
// Depends on bmp2rgb_pkg, bmp2rgb_front, bmp2rgb_queue and bmp2rgb_back.
//
// The block takes one file byte per cycle unless the full queue stalls the
// input, and turns a 24-bit BMP stream into a clear-screen request, RGB565
// pixel requests with screen coordinates, and a done or short-header request
// at the end of the file. Each byte is parsed combinationally, so input bytes
// are accepted back to back while the queue has room; a byte that yields two
// results (a pixel or the clear plus the end of file) holds the output
// register for both; the four-entry queue between parser and output absorbs
// that. There is no clearing pass; the block is ready right after reset.
`default_nettype none

module bmp24_stream_to_rgb565_pixels #(
  parameter int SCREEN_COLS = bmp2rgb_pkg::ScreenColsDefault,
  parameter int SCREEN_ROWS = bmp2rgb_pkg::ScreenRowsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bmp2rgb_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bmp2rgb_pkg::out_item_t out_item_o
);

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  bmp2rgb_pkg::bundle_t bundle;
  bmp2rgb_pkg::bundle_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bmp2rgb_front #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  bmp2rgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  bmp2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/bmp2rgb_checker.sv
// Port-level checks for the BMP to RGB565 decoder and their bind.
// Depends on bmp2rgb_pkg and bmp24_stream_to_rgb565_pixels.
`default_nettype none

module bmp2rgb_checker #(
  parameter int SCREEN_COLS = bmp2rgb_pkg::ScreenColsDefault,
  parameter int SCREEN_ROWS = bmp2rgb_pkg::ScreenRowsDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input bmp2rgb_pkg::in_item_t  in_item_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input bmp2rgb_pkg::out_item_t out_item_o
);

  logic is_pixel;
  logic in_accept;

  assign is_pixel  = out_valid_o && (out_item_o.kind == bmp2rgb_pkg::KIND_PIXEL);
  assign in_accept = in_valid_i && !in_stall_o;

  // A stalled request keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output request changed while stalled");

  // Only pixel requests carry coordinates and a color.
  a_non_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_pixel |->
      out_item_o.pixel_x == '0 && out_item_o.pixel_y == '0 && out_item_o.color == '0)
    else $error("non-pixel request with nonzero payload");

  // Pixels are clipped to the screen.
  a_pixel_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_pixel |-> (SCREEN_COLS > 512 || 32'(out_item_o.pixel_x) < 32'(SCREEN_COLS)) &&
                 (SCREEN_ROWS > 256 || 32'(out_item_o.pixel_y) < 32'(SCREEN_ROWS)))
    else $error("pixel outside the screen");

  // The end-of-file request always closes the run of its byte.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == bmp2rgb_pkg::KIND_DONE ||
                    out_item_o.kind == bmp2rgb_pkg::KIND_HDR_ERR) |->
      out_item_o.last_in_run)
    else $error("end-of-file request not last in its run");

  // With the output idle and nothing accepted, nothing is left to drain, so no request can appear.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_accept ##1 !out_valid_o && !in_accept |=> !out_valid_o)
    else $error("request appeared without input");

endmodule

bind bmp24_stream_to_rgb565_pixels bmp2rgb_checker #(
  .SCREEN_COLS(SCREEN_COLS),
  .SCREEN_ROWS(SCREEN_ROWS)
) u_bmp2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
